// ===== hdl/alm_pkg.sv =====
`default_nettype none

package alm_pkg;

  // list geometry; null is the pointer value DEPTH
  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int PTR_W      = $clog2(DEPTH + 1);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // channel field widths
  localparam int REQ_W = 3;
  localparam int DIN_W = 32;
  localparam int OUT_W = 32;
  localparam int ST_W  = 2;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_HEAD = 3'd0,
    REQ_ADD_TAIL = 3'd1,
    REQ_DEL_HEAD = 3'd2,
    REQ_DEL_TAIL = 3'd3,
    REQ_CLEAR    = 3'd4,
    REQ_READ_OUT = 3'd5
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // datapath operations of one control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_ADDH,
    OP_WALK_INIT,
    OP_WALK,
    OP_LINK_TAIL,
    OP_TAKE_FREE,
    OP_DELH,
    OP_CUT,
    OP_FREE_CUR,
    OP_CLEAR,
    OP_RD_ISSUE,
    OP_EMIT_DATA,
    OP_EMIT_OK,
    OP_EMIT_FULL,
    OP_EMIT_EMPTY
  } uop_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_DISPATCH,
    C_HEAD_NIL,
    C_FREE_NIL,
    C_WALK_MORE,
    C_PREV_NIL,
    C_NOT_FIN
  } ucond_t;

  localparam int STEP_W = 5;

  // true: jump to target; false: next step, or back to fetch when end_seq is set
  typedef struct packed {
    uop_t               op;
    ucond_t             cond;
    logic [STEP_W-1:0]  target;
    logic               end_seq;
  } uword_t;

  localparam logic [STEP_W-1:0] S_FETCH = 5'd0;
  localparam logic [STEP_W-1:0] S_AH0   = 5'd1;
  localparam logic [STEP_W-1:0] S_AH1   = 5'd2;
  localparam logic [STEP_W-1:0] S_AT0   = 5'd3;
  localparam logic [STEP_W-1:0] S_AT1   = 5'd4;
  localparam logic [STEP_W-1:0] S_AT2   = 5'd5;
  localparam logic [STEP_W-1:0] S_AT3   = 5'd6;
  localparam logic [STEP_W-1:0] S_AT4   = 5'd7;
  localparam logic [STEP_W-1:0] S_DH0   = 5'd8;
  localparam logic [STEP_W-1:0] S_DH1   = 5'd9;
  localparam logic [STEP_W-1:0] S_DT0   = 5'd10;
  localparam logic [STEP_W-1:0] S_DT1   = 5'd11;
  localparam logic [STEP_W-1:0] S_DT2   = 5'd12;
  localparam logic [STEP_W-1:0] S_DT3   = 5'd13;
  localparam logic [STEP_W-1:0] S_DT4   = 5'd14;
  localparam logic [STEP_W-1:0] S_CL0   = 5'd15;
  localparam logic [STEP_W-1:0] S_RO0   = 5'd16;
  localparam logic [STEP_W-1:0] S_RO1   = 5'd17;
  localparam logic [STEP_W-1:0] S_RO2   = 5'd18;
  localparam logic [STEP_W-1:0] S_OK    = 5'd19;
  localparam logic [STEP_W-1:0] S_FULL  = 5'd20;
  localparam logic [STEP_W-1:0] S_EMPTY = 5'd21;

  // control store
  function automatic uword_t ucode(input logic [STEP_W-1:0] s);
    uword_t w;
    unique case (s)
      S_FETCH: w = '{OP_FETCH,     C_DISPATCH,  S_FETCH, 1'b0};
      // add at head
      S_AH0:   w = '{OP_NOP,       C_FREE_NIL,  S_FULL,  1'b0};
      S_AH1:   w = '{OP_ADDH,      C_ALWAYS,    S_OK,    1'b0};
      // add at tail
      S_AT0:   w = '{OP_WALK_INIT, C_HEAD_NIL,  S_AH0,   1'b0};
      S_AT1:   w = '{OP_NOP,       C_FREE_NIL,  S_FULL,  1'b0};
      S_AT2:   w = '{OP_WALK,      C_WALK_MORE, S_AT2,   1'b0};
      S_AT3:   w = '{OP_LINK_TAIL, C_NEVER,     S_FETCH, 1'b0};
      S_AT4:   w = '{OP_TAKE_FREE, C_ALWAYS,    S_OK,    1'b0};
      // delete head
      S_DH0:   w = '{OP_NOP,       C_HEAD_NIL,  S_EMPTY, 1'b0};
      S_DH1:   w = '{OP_DELH,      C_ALWAYS,    S_OK,    1'b0};
      // delete tail
      S_DT0:   w = '{OP_WALK_INIT, C_HEAD_NIL,  S_EMPTY, 1'b0};
      S_DT1:   w = '{OP_WALK,      C_WALK_MORE, S_DT1,   1'b0};
      S_DT2:   w = '{OP_NOP,       C_PREV_NIL,  S_DH1,   1'b0};
      S_DT3:   w = '{OP_CUT,       C_NEVER,     S_FETCH, 1'b0};
      S_DT4:   w = '{OP_FREE_CUR,  C_ALWAYS,    S_OK,    1'b0};
      // clear
      S_CL0:   w = '{OP_CLEAR,     C_ALWAYS,    S_OK,    1'b0};
      // read out
      S_RO0:   w = '{OP_WALK_INIT, C_HEAD_NIL,  S_EMPTY, 1'b0};
      S_RO1:   w = '{OP_RD_ISSUE,  C_NEVER,     S_FETCH, 1'b0};
      S_RO2:   w = '{OP_EMIT_DATA, C_NOT_FIN,   S_RO1,   1'b1};
      // single status results
      S_OK:    w = '{OP_EMIT_OK,    C_ALWAYS,   S_FETCH, 1'b0};
      S_FULL:  w = '{OP_EMIT_FULL,  C_ALWAYS,   S_FETCH, 1'b0};
      S_EMPTY: w = '{OP_EMIT_EMPTY, C_ALWAYS,   S_FETCH, 1'b0};
      default: w = '{OP_NOP,        C_ALWAYS,   S_FETCH, 1'b0};
    endcase
    return w;
  endfunction

  // entry step of each request type; unknown types just report ok
  function automatic logic [STEP_W-1:0] dispatch(input req_t r);
    logic [STEP_W-1:0] s;
    unique case (r)
      REQ_ADD_HEAD: s = S_AH0;
      REQ_ADD_TAIL: s = S_AT0;
      REQ_DEL_HEAD: s = S_DH0;
      REQ_DEL_TAIL: s = S_DT0;
      REQ_CLEAR:    s = S_CL0;
      REQ_READ_OUT: s = S_RO0;
      default:      s = S_OK;
    endcase
    return s;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] store_val(input logic [DIN_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] sext_out(input logic [DATA_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    return w[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/alm_in_if.sv =====
`default_nettype none

interface alm_in_if import alm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [DIN_W-1:0] data_in;

  modport source (output valid, output req_type, output data_in, input ready);
  modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/alm_out_if.sv =====
`default_nettype none

interface alm_out_if import alm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [OUT_W-1:0] data_out;
  logic                    last;

  modport source (output valid, output status, output data_out, output last, input ready);
  modport sink   (input valid, input status, input data_out, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/alm_ram.sv =====
`default_nettype none

module alm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/array_linked_list_manager.sv =====
// array_linked_list_manager: singly linked list kept in a fixed slot store,
// with unused slots chained on a free list.
// channels: in_req (req_type, data_in) takes one request per transfer;
//   out_rsp (status, data_out, last) gives the results, last marks the final
//   result of a request. read out gives one result per element, head to tail
//   (one empty result on an empty list); every other request gives exactly one result.
// control is a microprogram: a step counter walks a small control store, one
//   control word per cycle, unless a step is held, driving the pointer and link datapath.
// a new request is taken only after the routine of the previous one is back
//   at fetch; add tail and delete tail walk the list, reading one link per step,
//   and read out handles each element as a link read, then an element read
//   from the slot ram.
//   the first result is valid in the cycle after its emitting step.
// a result sits in an output register; the sequencer goes on while it waits
//   and only stops at the next emitting step while the receiver stalls.
// reset: empty list, free chain 0 -> 1 -> ... -> DEPTH-1, all links restored
//   at once; no clearing pass. element slots hold no value until written.
`default_nettype none

module array_linked_list_manager import alm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  alm_in_if.sink     in_req,
  alm_out_if.source  out_rsp
);

  // sequencer
  logic [STEP_W-1:0] pc_r, pc_nxt;
  uword_t            uw;
  logic              cond_ok;
  logic              is_emit;
  logic              blocked;

  // list pointers and walk registers
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  free_r, free_nxt;
  logic [PTR_W-1:0]  cur_r, cur_nxt;
  logic [PTR_W-1:0]  prev_r, prev_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              fin_r, fin_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;

  // link store, one read and one write port
  logic [PTR_W-1:0]  link_r [DEPTH];
  logic              link_we;
  logic              link_clr;
  logic [IDX_W-1:0]  link_wa;
  logic [PTR_W-1:0]  link_wd;
  logic [PTR_W-1:0]  lk_addr;
  logic [PTR_W-1:0]  lk_raw;
  logic [PTR_W-1:0]  lk_next;
  logic              walk_more;

  // element slots
  logic              ram_we;
  logic              ram_re;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // output register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  assign uw = ucode(pc_r);

  // link read port: successor of the slot the current op looks at
  always_comb begin
    unique case (uw.op)
      OP_ADDH, OP_TAKE_FREE: lk_addr = free_r;
      OP_DELH:               lk_addr = head_r;
      default:               lk_addr = cur_r;
    endcase
    lk_raw = NIL;
    if (lk_addr < NIL) begin
      lk_raw = link_r[lk_addr[IDX_W-1:0]];
    end
    lk_next = (lk_raw >= NIL) ? NIL : lk_raw;
  end

  // walks are bounded by DEPTH link steps
  assign walk_more = (lk_next != NIL) && (cnt_r < CNT_W'(DEPTH));

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     cond_ok = 1'b0;
      C_ALWAYS:    cond_ok = 1'b1;
      C_DISPATCH:  cond_ok = 1'b1;
      C_HEAD_NIL:  cond_ok = (head_r == NIL);
      C_FREE_NIL:  cond_ok = (free_r == NIL);
      C_WALK_MORE: cond_ok = walk_more;
      C_PREV_NIL:  cond_ok = (prev_r == NIL);
      C_NOT_FIN:   cond_ok = !fin_r;
      default:     cond_ok = 1'b0;
    endcase
  end

  assign is_emit = (uw.op == OP_EMIT_DATA) || (uw.op == OP_EMIT_OK) ||
                   (uw.op == OP_EMIT_FULL) || (uw.op == OP_EMIT_EMPTY);

  // fetch waits for a request, an emitting step waits for a free output register
  assign blocked = (is_emit && out_valid_r && !out_rsp.ready) ||
                   ((uw.op == OP_FETCH) && !in_req.valid);

  // datapath
  always_comb begin
    head_nxt       = head_r;
    free_nxt       = free_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    cnt_nxt        = cnt_r;
    fin_nxt        = fin_r;
    data_nxt       = data_r;
    link_we        = 1'b0;
    link_clr       = 1'b0;
    link_wa        = cur_r[IDX_W-1:0];
    link_wd        = NIL;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;

    // receiver took the waiting result
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (!blocked) begin
      unique case (uw.op)
        OP_NOP: begin
        end
        OP_FETCH: begin
          data_nxt = store_val(in_req.data_in);
        end
        OP_ADDH: begin
          // take the first free slot and put it in front
          ram_we   = 1'b1;
          link_we  = 1'b1;
          link_wa  = free_r[IDX_W-1:0];
          link_wd  = head_r;
          free_nxt = lk_next;
          head_nxt = free_r;
        end
        OP_WALK_INIT: begin
          cur_nxt  = head_r;
          prev_nxt = NIL;
          cnt_nxt  = '0;
        end
        OP_WALK: begin
          if (walk_more) begin
            prev_nxt = cur_r;
            cur_nxt  = lk_next;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        OP_LINK_TAIL: begin
          // old tail points to the new slot
          ram_we  = 1'b1;
          link_we = 1'b1;
          link_wa = cur_r[IDX_W-1:0];
          link_wd = free_r;
        end
        OP_TAKE_FREE: begin
          // new slot ends the list, free chain moves on
          link_we  = 1'b1;
          link_wa  = free_r[IDX_W-1:0];
          link_wd  = NIL;
          free_nxt = lk_next;
        end
        OP_DELH: begin
          link_we  = 1'b1;
          link_wa  = head_r[IDX_W-1:0];
          link_wd  = free_r;
          free_nxt = head_r;
          head_nxt = lk_next;
        end
        OP_CUT: begin
          // node before the tail becomes the tail
          link_we = 1'b1;
          link_wa = prev_r[IDX_W-1:0];
          link_wd = NIL;
        end
        OP_FREE_CUR: begin
          link_we  = 1'b1;
          link_wa  = cur_r[IDX_W-1:0];
          link_wd  = free_r;
          free_nxt = cur_r;
        end
        OP_CLEAR: begin
          link_clr = 1'b1;
          head_nxt = NIL;
          free_nxt = '0;
        end
        OP_RD_ISSUE: begin
          // element read goes out now, data is there next step
          ram_re  = 1'b1;
          fin_nxt = (lk_next == NIL) ||
                    (({1'b0, cnt_r} + 1'b1) >= (CNT_W + 1)'(DEPTH));
          cur_nxt = lk_next;
          cnt_nxt = cnt_r + 1'b1;
        end
        OP_EMIT_DATA: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = sext_out(ram_rdata);
          out_last_nxt   = fin_r;
        end
        OP_EMIT_OK: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = '0;
          out_last_nxt   = 1'b1;
        end
        OP_EMIT_FULL: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FULL;
          out_data_nxt   = '0;
          out_last_nxt   = 1'b1;
        end
        OP_EMIT_EMPTY: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_EMPTY;
          out_data_nxt   = '0;
          out_last_nxt   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // step counter: hold, dispatch, jump, fall through or return to fetch
  always_comb begin
    priority if (blocked) begin
      pc_nxt = pc_r;
    end else if (uw.cond == C_DISPATCH) begin
      pc_nxt = dispatch(req_t'(in_req.req_type));
    end else if (cond_ok) begin
      pc_nxt = uw.target;
    end else if (uw.end_seq) begin
      pc_nxt = S_FETCH;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    // payload, no reset needed
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    fin_r        <= fin_nxt;
    data_r       <= data_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;

    if (!rst_n) begin
      pc_r        <= S_FETCH;
      head_r      <= NIL;
      free_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        link_r[i] <= PTR_W'(i + 1);
      end
    end else begin
      pc_r        <= pc_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (link_clr) begin
        for (int i = 0; i < DEPTH; i++) begin
          link_r[i] <= PTR_W'(i + 1);
        end
      end else if (link_we) begin
        link_r[link_wa] <= link_wd;
      end
    end
  end

  alm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_elem_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_r[IDX_W-1:0]),
    .wdata (data_r),
    .re    (ram_re),
    .raddr (cur_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign in_req.ready     = (uw.op == OP_FETCH);
  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.status   = out_status_r;
  assign out_rsp.data_out = out_data_r;
  assign out_rsp.last     = out_last_r;

  // the head slot is never also the first slot of the free chain
  assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NIL) || (head_r != free_r))
    else $error("head and free pointer share a slot");

  // a request transfer starts a routine, so no second transfer right after it
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request taken while routine running");

  // error results are always single results
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && (out_status_r != ST_OK)) |-> out_rsp.last)
    else $error("error status without last");

  // walk counter stays within the link bound
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("walk counter beyond depth");

endmodule

`default_nettype wire

// ===== bench/array_linked_list_manager_test.sv =====
`timescale 1ns / 1ps

module array_linked_list_manager_test;
  import alm_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 170;
  localparam int N_DIRECTED   = 25;
  localparam int REPORT_MAX   = 10;
  // worst case is far below this: ~205 requests, each with a bounded list walk
  // plus DEPTH results behind a randomly stalling receiver
  localparam int CYCLE_LIMIT  = 200000;
  // quiet time after the last expected result, longer than any walk
  localparam int DRAIN_CYCLES = 4 * DEPTH + 16;
  // request codes the block accepts and answers with a plain ok
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  // one result as it should appear on out_rsp
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OUT_W-1:0] data;
    logic             last;
  } rsp_t;

  // status typed into the directed table, applied to a single-result request
  typedef struct packed {
    bit              typed;
    logic [ST_W-1:0] st;
  } fixed_status_t;

  // one row of the directed table
  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic [DIN_W-1:0] value;
    bit               typed;
    logic [ST_W-1:0]  st;
  } step_t;

  logic clk;
  logic rst_n;
  bit   steady_run;
  int   fail_count;
  int   cycle_count;

  rsp_t          expected_rsp_q [$];
  fixed_status_t fixed_status_q [$];
  step_t         directed_steps [N_DIRECTED];

  // mirror of the list: slot values, slot links, head and free chain starts
  // a pointer equal to DEPTH means null
  logic [DATA_WIDTH-1:0] slot_val [DEPTH];
  int unsigned           slot_link [DEPTH];
  int unsigned           head_slot;
  int unsigned           free_slot;

  alm_in_if  in_req ();
  alm_out_if out_rsp ();

  array_linked_list_manager DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // list mirror
  // ---------------------------------------------------------------------------

  // successor of a slot, any out-of-range link reads as null
  function automatic int unsigned link_after(input int unsigned s);
    if (s >= DEPTH) return DEPTH;
    return (slot_link[s] >= DEPTH) ? DEPTH : slot_link[s];
  endfunction

  // empty list, free chain 0 -> 1 -> ... -> DEPTH-1
  function automatic void rebuild_free_chain();
    for (int i = 0; i < DEPTH; i++) slot_link[i] = i + 1;
    head_slot = DEPTH;
    free_slot = 0;
  endfunction

  // take the first free slot and put it in front of the head
  function automatic status_t push_front_elem(input logic [DIN_W-1:0] value);
    int unsigned s;
    s = free_slot;
    if (s >= DEPTH) return ST_FULL;
    slot_val[s]  = value[DATA_WIDTH-1:0];
    free_slot    = link_after(s);
    slot_link[s] = head_slot;
    head_slot    = s;
    return ST_OK;
  endfunction

  // unlink the head and return its slot to the front of the free chain
  function automatic status_t pop_front_elem();
    int unsigned h;
    h = head_slot;
    if (h >= DEPTH) return ST_EMPTY;
    head_slot    = link_after(h);
    slot_link[h] = free_slot;
    free_slot    = h;
    return ST_OK;
  endfunction

  // apply one accepted request to the mirror and queue the results it causes
  function automatic void predict_list_results(input logic [REQ_W-1:0] kind,
                                               input logic [DIN_W-1:0] value,
                                               input fixed_status_t fixed);
    status_t     st;
    int unsigned cur, prev, s, nx;
    int          n;
    logic signed [DATA_WIDTH-1:0] elem;
    st = ST_OK;
    case (kind)
      REQ_ADD_HEAD: st = push_front_elem(value);
      REQ_ADD_TAIL: begin
        // empty list falls back to add at head
        if (head_slot >= DEPTH) begin
          st = push_front_elem(value);
        end else if (free_slot >= DEPTH) begin
          st = ST_FULL;
        end else begin
          cur = head_slot;
          for (n = 0; n < DEPTH && link_after(cur) < DEPTH; n++) cur = link_after(cur);
          s              = free_slot;
          slot_val[s]    = value[DATA_WIDTH-1:0];
          free_slot      = link_after(s);
          slot_link[s]   = DEPTH;
          slot_link[cur] = s;
        end
      end
      REQ_DEL_HEAD: st = pop_front_elem();
      REQ_DEL_TAIL: begin
        if (head_slot >= DEPTH) begin
          st = ST_EMPTY;
        end else begin
          prev = DEPTH;
          cur  = head_slot;
          for (n = 0; n < DEPTH && link_after(cur) < DEPTH; n++) begin
            prev = cur;
            cur  = link_after(cur);
          end
          // single element: same as delete head
          if (prev >= DEPTH) begin
            st = pop_front_elem();
          end else begin
            slot_link[prev] = DEPTH;
            slot_link[cur]  = free_slot;
            free_slot       = cur;
          end
        end
      end
      REQ_CLEAR: rebuild_free_chain();
      REQ_READ_OUT: begin
        if (head_slot >= DEPTH) begin
          st = ST_EMPTY;
        end else begin
          // one result per element, head to tail, last on the final one
          cur = head_slot;
          n   = 0;
          while (cur < DEPTH && n < DEPTH) begin
            nx   = link_after(cur);
            elem = slot_val[cur];
            expected_rsp_q.push_back('{ST_OK, OUT_W'(elem),
                                       (nx >= DEPTH) || (n + 1 >= DEPTH)});
            n++;
            cur = nx;
          end
          return;
        end
      end
      default: ;  // spare codes only answer ok
    endcase
    expected_rsp_q.push_back('{fixed.typed ? fixed.st : st, OUT_W'(0), 1'b1});
  endfunction

  // ---------------------------------------------------------------------------
  // request side: one transfer per call, entered and left at a falling edge
  // ---------------------------------------------------------------------------

  task automatic offer_request(input logic [REQ_W-1:0] kind, input logic [DIN_W-1:0] value,
                               input bit typed, input logic [ST_W-1:0] st);
    // random gaps before the request, none during the steady stretch
    while (!steady_run && $urandom_range(99) < 26) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    fixed_status_q.push_back('{typed, st});
    in_req.valid    <= 1'b1;
    in_req.req_type <= kind;
    in_req.data_in  <= value;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly random words, with the extremes mixed in
  function automatic logic [DIN_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, checked against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_rsp.ready <= steady_run || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin : scoreboard
    fixed_status_t fixed;
    rsp_t          want;
    if (rst_n) begin
      // expectations are formed at the request transfer, before any result check
      if (in_req.valid && in_req.ready) begin
        fixed = (fixed_status_q.size() != 0) ? fixed_status_q.pop_front() : '0;
        predict_list_results(in_req.req_type, in_req.data_in, fixed);
      end
      if (out_rsp.valid && out_rsp.ready) begin
        if (expected_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result: status %0d data %h last %b",
                     out_rsp.status, out_rsp.data_out, out_rsp.last);
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_rsp.status !== want.status || out_rsp.data_out !== want.data ||
              out_rsp.last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display({"result mismatch: expected status %0d data %h last %b, ",
                        "got status %0d data %h last %b"},
                       want.status, want.data, want.last,
                       out_rsp.status, out_rsp.data_out, out_rsp.last);
          end
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int               work_items;
    int               pick;
    bit               fill_phase;
    logic [REQ_W-1:0] kind;

    clk             = 1'b0;
    rst_n           = 1'b0;
    steady_run      = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    in_req.valid    = 1'b0;
    in_req.req_type = '0;
    in_req.data_in  = '0;
    out_rsp.ready   = 1'b0;
    rebuild_free_chain();
    for (int i = 0; i < DEPTH; i++) slot_val[i] = '0;

    // directed part: status typed in where it is plain, otherwise predicted
    directed_steps = '{
      '{REQ_READ_OUT, 32'h0000_0000, 1'b1, ST_EMPTY},  // read out right after reset
      '{REQ_DEL_HEAD, 32'h0000_0000, 1'b1, ST_EMPTY},  // delete on an empty list
      '{REQ_DEL_TAIL, 32'hFFFF_FFFF, 1'b1, ST_EMPTY},
      '{REQ_ADD_TAIL, 32'h7FFF_FFFF, 1'b1, ST_OK},     // add at tail on empty list
      '{REQ_ADD_HEAD, 32'h8000_0000, 1'b1, ST_OK},
      '{REQ_ADD_TAIL, 32'h0000_0000, 1'b1, ST_OK},
      '{REQ_ADD_HEAD, 32'hFFFF_FFFF, 1'b1, ST_OK},
      '{REQ_READ_OUT, 32'h0000_0000, 1'b0, ST_OK},
      '{REQ_ADD_TAIL, 32'h0000_0001, 1'b0, ST_OK},
      '{REQ_ADD_HEAD, 32'h0000_0002, 1'b0, ST_OK},
      '{REQ_ADD_TAIL, 32'h0000_0003, 1'b0, ST_OK},
      '{REQ_ADD_HEAD, 32'h0000_0004, 1'b0, ST_OK},     // list now full
      '{REQ_ADD_HEAD, 32'h0000_0005, 1'b1, ST_FULL},   // add on a full list
      '{REQ_ADD_TAIL, 32'h0000_0006, 1'b1, ST_FULL},
      '{REQ_READ_OUT, 32'h0000_0000, 1'b0, ST_OK},     // longest read out
      '{REQ_SPARE_6,  32'hDEAD_BEEF, 1'b1, ST_OK},     // spare codes
      '{REQ_SPARE_7,  32'h1234_5678, 1'b1, ST_OK},
      '{REQ_DEL_TAIL, 32'h0000_0000, 1'b0, ST_OK},
      '{REQ_DEL_HEAD, 32'h0000_0000, 1'b0, ST_OK},
      '{REQ_READ_OUT, 32'h0000_0000, 1'b0, ST_OK},
      '{REQ_CLEAR,    32'h0000_0000, 1'b1, ST_OK},
      '{REQ_READ_OUT, 32'h0000_0000, 1'b1, ST_EMPTY},
      '{REQ_ADD_HEAD, 32'h5A5A_5A5A, 1'b0, ST_OK},
      '{REQ_DEL_TAIL, 32'h0000_0000, 1'b0, ST_OK},     // delete tail with one element
      '{REQ_READ_OUT, 32'h0000_0000, 1'b1, ST_EMPTY}
    };

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i])
      offer_request(directed_steps[i].kind, directed_steps[i].value,
                    directed_steps[i].typed, directed_steps[i].st);

    // random part: alternate fill-heavy and drain-heavy stretches so the list
    // swings between full and empty; spare codes do not count as work
    work_items = 0;
    while (work_items < RANDOM_ITEMS) begin
      fill_phase = ((work_items / 30) % 2) == 0;
      steady_run = (work_items >= 80) && (work_items < 140);
      pick       = $urandom_range(99);
      if (fill_phase) begin
        if      (pick < 30) kind = REQ_ADD_HEAD;
        else if (pick < 60) kind = REQ_ADD_TAIL;
        else if (pick < 70) kind = REQ_DEL_HEAD;
        else if (pick < 80) kind = REQ_DEL_TAIL;
        else if (pick < 92) kind = REQ_READ_OUT;
        else if (pick < 95) kind = REQ_CLEAR;
        else                kind = pick[0] ? REQ_SPARE_7 : REQ_SPARE_6;
      end else begin
        if      (pick < 15) kind = REQ_ADD_HEAD;
        else if (pick < 30) kind = REQ_ADD_TAIL;
        else if (pick < 52) kind = REQ_DEL_HEAD;
        else if (pick < 75) kind = REQ_DEL_TAIL;
        else if (pick < 92) kind = REQ_READ_OUT;
        else if (pick < 95) kind = REQ_CLEAR;
        else                kind = pick[0] ? REQ_SPARE_7 : REQ_SPARE_6;
      end
      offer_request(kind, pick_value(), 1'b0, ST_OK);
      if (kind != REQ_SPARE_6 && kind != REQ_SPARE_7) work_items++;
    end
    steady_run   = 1'b0;
    in_req.valid <= 1'b0;

    // let every expected result arrive, then watch for strays
    while (expected_rsp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && expected_rsp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
